// ----- design/sis_pkg.sv -----
// Shared types and constants for the stable index sorter.
package sis_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned PosWidth   = 6;

  typedef struct packed {
    logic signed [ValueWidth-1:0] value;
    logic [PosWidth-1:0]          pos;
  } sis_entry_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } sis_ctrl_t;

endpackage

// ----- design/stable_index_sorter.sv -----
// Stable index sorter: insertion chain of cells, then a sorted drain of arrival positions.
// Load: one element per cycle; each transfer is placed by the chain in the cycle it arrives.
// Drain: after the closing element, one position per cycle from the head cell while out_ready
// holds; input is held off until the last position of the set transfers.
// The first position is offered in the cycle after the closing element transfers.
// Reset clears the element count, overflow flag and state; cell contents are left as they are.
module stable_index_sorter
  import sis_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [ValueWidth-1:0] value,
  input  logic                         last_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [PosWidth-1:0]          position,
  output logic                         last_out,
  output logic                         truncated
);

  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

  state_t        state;
  logic [CW-1:0] count;
  logic          overflow;

  logic          in_xfer;
  logic          out_xfer;
  logic          full;
  sis_ctrl_t     ctrl;
  sis_entry_t    new_ent;
  sis_entry_t    ents [MAX_ITEMS];
  logic          gts  [MAX_ITEMS];

  assign in_ready  = state == ST_LOAD;
  assign out_valid = state == ST_DRAIN;
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;
  assign full      = count == CW'(MAX_ITEMS);

  assign ctrl.insert = in_xfer && !full;
  assign ctrl.shift  = out_xfer;

  assign new_ent.value = value;
  assign new_ent.pos   = PosWidth'(count);

  assign position  = ents[0].pos;
  assign last_out  = count == CW'(1);
  assign truncated = overflow;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    sis_entry_t prev_e;
    sis_entry_t next_e;
    logic       prev_g;

    if (i == 0) begin : g_head
      assign prev_e = new_ent;
      assign prev_g = 1'b0;
    end else begin : g_body
      assign prev_e = ents[i-1];
      assign prev_g = gts[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign next_e = ents[i];
    end else begin : g_mid
      assign next_e = ents[i+1];
    end

    sis_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .count        (count),
      .new_ent      (new_ent),
      .prev_ent     (prev_e),
      .prev_greater (prev_g),
      .next_ent     (next_e),
      .ent          (ents[i]),
      .greater      (gts[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      count    <= '0;
      overflow <= 1'b0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (in_xfer) begin
            if (full) begin
              overflow <= 1'b1;
            end else begin
              count <= count + CW'(1);
            end
            if (last_in) begin
              state <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (out_xfer) begin
            count <= count - CW'(1);
            if (count == CW'(1)) begin
              state    <= ST_LOAD;
              overflow <= 1'b0;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

endmodule

// ----- design/sis_cell.sv -----
// One cell of the sorting chain: holds one entry, inserts in order or shifts down.
module sis_cell
  import sis_pkg::*;
#(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 7
) (
  input  logic          clk,
  input  sis_ctrl_t     ctrl,
  input  logic [CW-1:0] count,
  input  sis_entry_t    new_ent,
  input  sis_entry_t    prev_ent,
  input  logic          prev_greater,
  input  sis_entry_t    next_ent,
  output sis_entry_t    ent,
  output logic          greater
);

  logic occupied;
  logic is_slot;

  assign occupied = CW'(IDX) < count;
  assign is_slot  = CW'(IDX) == count;
  assign greater  = occupied && (ent.value > new_ent.value);

  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      if (greater || is_slot) begin
        ent <= prev_greater ? prev_ent : new_ent;
      end
    end else if (ctrl.shift) begin
      ent <= next_ent;
    end
  end

endmodule
